[rtl/heightmap_normal_generator_core_defines.svh]
// ----------------------------------------------------------------------------
// heightmap normal generator assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_NORMAL_GENERATOR_CORE_DEFINES_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_CORE_DEFINES_SVH

// property checked outside reset
`define HNORM_ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hnorm assertion failed");

// property checked on every edge, reset included
`define HNORM_ASSERT_RAW(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hnorm reset assertion failed");

`endif

[rtl/hnorm_pkg.sv]
// ----------------------------------------------------------------------------
// hnorm_pkg
// shared types, constants and helpers of the heightmap normal generator
// ----------------------------------------------------------------------------
package hnorm_pkg;

  localparam int MAX_SIDE_DEF = 1024;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_SIDE    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT_GAIN   = 2'd1;
  localparam logic [1:0] CFG_HEIGHT_ENABLE = 2'd2;

  localparam logic [10:0] IMAGE_SIDE_RST    = 11'd256;
  localparam logic [15:0] HEIGHT_GAIN_RST   = 16'd256;
  localparam logic        HEIGHT_ENABLE_RST = 1'b1;

  // item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 17;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_CUR, ST_RD_NBR, ST_WRITE,
    ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_MATH, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    M_IDLE, M_SQ_A, M_SQ_B, M_SQRT, M_DIV_LOAD, M_DIV, M_DONE
  } math_state_t;

  typedef enum logic [1:0] {
    COMP_X, COMP_Y, COMP_Z
  } comp_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic        [14:0] ny;
    logic signed [15:0] nz;
  } hnorm_vec_t;

  // pixel level 2p-255
  function automatic logic signed [9:0] pix_level(input logic [7:0] p);
    pix_level = $signed({1'b0, p, 1'b0}) - 10'sd255;
  endfunction

  // signed component from rounded magnitude, saturated
  function automatic logic signed [15:0] sat_signed(input logic [16:0] q, input logic neg);
    logic signed [15:0] r;
    if (neg) begin
      if (q >= 17'd32768) r = 16'sh8000;
      else r = -$signed(q[15:0]);
    end else begin
      if (q >= 17'd32767) r = 16'sh7fff;
      else r = $signed(q[15:0]);
    end
    sat_signed = r;
  endfunction

  function automatic logic [14:0] sat_unsigned(input logic [16:0] q);
    sat_unsigned = (q >= 17'd32767) ? 15'h7fff : q[14:0];
  endfunction

endpackage

[rtl/hnorm_ram.sv]
// ----------------------------------------------------------------------------
// hnorm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module hnorm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hnorm_pkg::MAX_SIDE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/hnorm_math.sv]
// ----------------------------------------------------------------------------
// hnorm_math
// sequential normalise unit: squares, bit-pair square root, long division
// ----------------------------------------------------------------------------
module hnorm_math (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [25:0]     a,
  input  logic signed [25:0]     b,
  output logic                   done,
  output hnorm_pkg::hnorm_vec_t  result
);

  hnorm_pkg::math_state_t state, state_next;
  hnorm_pkg::comp_t       comp;

  logic [24:0] mag_a, mag_b;
  logic        neg_a, neg_b;
  logic [24:0] sq_op;
  logic [49:0] sq;
  logic [51:0] n2;
  logic [63:0] xsh;
  logic [32:0] rem;
  logic [31:0] root;
  logic [4:0]  cnt;
  logic [34:0] s_cand;
  logic [34:0] s_trial;
  logic        s_ge;
  logic [32:0] rem_next;
  logic [24:0] div_mag;
  logic        div_neg;
  logic [46:0] numer;
  logic [31:0] drem;
  logic [16:0] dlow, q;
  logic [32:0] d_cand;
  logic        d_ge;
  logic [31:0] drem_next;
  logic [16:0] q_next;

  assign sq_op = (state == hnorm_pkg::M_SQ_B) ? mag_b : mag_a;
  assign sq    = sq_op * sq_op;

  // one root bit per cycle
  assign s_cand   = {rem[32:0], xsh[63:62]};
  assign s_trial  = {1'b0, root, 2'b01};
  assign s_ge     = s_cand >= s_trial;
  assign rem_next = s_ge ? 33'(s_cand - s_trial) : s_cand[32:0];

  always_comb begin
    unique case (comp)
      hnorm_pkg::COMP_X: begin div_mag = mag_a;  div_neg = neg_a; end
      hnorm_pkg::COMP_Y: begin div_mag = 25'd512; div_neg = 1'b0; end
      hnorm_pkg::COMP_Z: begin div_mag = mag_b;  div_neg = neg_b; end
      default:           begin div_mag = 25'd0;  div_neg = 1'b0; end
    endcase
  end

  // numerator with the half divisor for round to nearest
  assign numer = {1'b0, div_mag, 21'd0} + 47'(root >> 1);

  // one quotient bit per cycle
  assign d_cand    = {drem, dlow[16]};
  assign d_ge      = d_cand >= {1'b0, root};
  assign drem_next = d_ge ? 32'(d_cand - {1'b0, root}) : d_cand[31:0];
  assign q_next    = {q[15:0], d_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hnorm_pkg::M_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      hnorm_pkg::M_IDLE:     if (start) state_next = hnorm_pkg::M_SQ_A;
      hnorm_pkg::M_SQ_A:     state_next = hnorm_pkg::M_SQ_B;
      hnorm_pkg::M_SQ_B:     state_next = hnorm_pkg::M_SQRT;
      hnorm_pkg::M_SQRT: begin
        if (cnt == 5'(hnorm_pkg::SQRT_STEPS - 1)) state_next = hnorm_pkg::M_DIV_LOAD;
      end
      hnorm_pkg::M_DIV_LOAD: state_next = hnorm_pkg::M_DIV;
      hnorm_pkg::M_DIV: begin
        if (cnt == 5'(hnorm_pkg::DIV_STEPS - 1)) begin
          state_next = (comp == hnorm_pkg::COMP_Z) ? hnorm_pkg::M_DONE
                                                   : hnorm_pkg::M_DIV_LOAD;
        end
      end
      hnorm_pkg::M_DONE: begin
        done       = 1'b1;
        state_next = hnorm_pkg::M_IDLE;
      end
      default: state_next = hnorm_pkg::M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      hnorm_pkg::M_IDLE: begin
        mag_a <= 25'(a[25] ? -a : a);
        mag_b <= 25'(b[25] ? -b : b);
        neg_a <= a[25];
        neg_b <= b[25];
        comp  <= hnorm_pkg::COMP_X;
      end
      hnorm_pkg::M_SQ_A: n2 <= 52'd262144 + 52'(sq);
      hnorm_pkg::M_SQ_B: begin
        xsh  <= {n2 + 52'(sq), 12'd0};
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end
      hnorm_pkg::M_SQRT: begin
        rem  <= rem_next;
        root <= {root[30:0], s_ge};
        xsh  <= {xsh[61:0], 2'b00};
        cnt  <= cnt + 5'd1;
      end
      hnorm_pkg::M_DIV_LOAD: begin
        drem <= 32'(numer[46:17]);
        dlow <= numer[16:0];
        q    <= '0;
        cnt  <= '0;
      end
      hnorm_pkg::M_DIV: begin
        drem <= drem_next;
        dlow <= {dlow[15:0], 1'b0};
        q    <= q_next;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'(hnorm_pkg::DIV_STEPS - 1)) begin
          unique case (comp)
            hnorm_pkg::COMP_X: begin
              result.nx <= hnorm_pkg::sat_signed(q_next, div_neg);
              comp      <= hnorm_pkg::COMP_Y;
            end
            hnorm_pkg::COMP_Y: begin
              result.ny <= hnorm_pkg::sat_unsigned(q_next);
              comp      <= hnorm_pkg::COMP_Z;
            end
            hnorm_pkg::COMP_Z: result.nz <= hnorm_pkg::sat_signed(q_next, div_neg);
            default: comp <= hnorm_pkg::COMP_X;
          endcase
        end
      end
      hnorm_pkg::M_DONE: cnt <= '0;
      default: cnt <= '0;
    endcase
  end

endmodule

[rtl/heightmap_normal_generator_core.sv]
// ----------------------------------------------------------------------------
// heightmap_normal_generator_core
// central difference normals and scaled heights for a raster heightmap
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  cfg     | cfg_we             | cfg_index, cfg_data
//  in      | in_valid/in_stall  | op, pixel_value
//  out     | out_valid/out_stall| height_value, normal_x/y/z, pixel_column/row, frame_last
//
//  an item producing a result keeps in_stall high until its result is loaded; hnorm_math
//  runs one shared square root (32 steps) and then three 17-step divisions for it
//  a first-row pixel makes two row-memory reads and a write back, then returns to idle,
//  an early flush item is taken and dropped while the sequencer stays idle
//  rst is synchronous; config and counters go to defaults, row stores are not cleared
//  a stalled result waits in the output register while the next item is accepted
//  and worked on; the sequencer only holds when a second result is ready first
// ----------------------------------------------------------------------------
module heightmap_normal_generator_core #(
  parameter int MAX_SIDE = hnorm_pkg::MAX_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_data,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [7:0]                  pixel_value,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [24:0]          height_value,
  output logic signed [15:0]          normal_x,
  output logic [14:0]                 normal_y,
  output logic signed [15:0]          normal_z,
  output logic [$clog2(MAX_SIDE)-1:0] pixel_column,
  output logic [$clog2(MAX_SIDE)-1:0] pixel_row,
  output logic                        frame_last
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = CW + 1;
  localparam int XW = (SW > 11) ? SW : 11;

  hnorm_pkg::state_t state, state_next;

  // configuration registers
  logic [10:0] image_side;
  logic [15:0] height_gain;
  logic        height_enable;

  // raster position of the next item
  logic [CW-1:0] col_cnt;
  logic [SW-1:0] row_cnt;

  // effective side and clamped column
  logic [XW-1:0] side_x;
  logic [SW-1:0] side;
  logic [CW-1:0] side_m1;
  logic [CW-1:0] col_cl;
  logic          draining;
  logic          accept;

  // item context latched at accept
  logic [CW-1:0] cur_col;
  logic [CW-1:0] cur_row;
  logic [7:0]    cur_pixel;
  logic          cur_drain, cur_emit, cur_down, cur_left, cur_right, cur_last_col;

  // row memory ports and captured neighbours
  logic          ram_we;
  logic [CW-1:0] ram_raddr_prev, ram_raddr_mid;
  logic [7:0]    prev_rdata, mid_rdata;
  logic [7:0]    prev_c, mid_c, prev_l, mid_r;

  // shared gain multiplier
  logic signed [9:0]  s_c, s_d, s_u, s_l, s_r;
  logic signed [9:0]  mul_op;
  logic signed [26:0] mul_res;
  logic signed [25:0] diff_a, diff_b;
  logic signed [24:0] hc;

  logic                  math_start, math_done;
  hnorm_pkg::hnorm_vec_t math_res;
  logic                  out_load;

  // side clamped to 2..MAX_SIDE
  always_comb begin
    side_x = XW'(image_side);
    if (side_x < XW'(2)) side = SW'(2);
    else if (side_x > XW'(MAX_SIDE)) side = SW'(MAX_SIDE);
    else side = SW'(side_x);
  end

  assign side_m1  = CW'(side - SW'(1));
  assign col_cl   = ({1'b0, col_cnt} > (side - SW'(1))) ? side_m1 : col_cnt;
  assign draining = row_cnt >= side;
  assign in_stall = state != hnorm_pkg::ST_IDLE;
  assign accept   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_side    <= hnorm_pkg::IMAGE_SIDE_RST;
      height_gain   <= hnorm_pkg::HEIGHT_GAIN_RST;
      height_enable <= hnorm_pkg::HEIGHT_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hnorm_pkg::CFG_IMAGE_SIDE:    image_side    <= cfg_data[10:0];
        hnorm_pkg::CFG_HEIGHT_GAIN:   height_gain   <= cfg_data;
        hnorm_pkg::CFG_HEIGHT_ENABLE: height_enable <= cfg_data[0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hnorm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    math_start = 1'b0;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    unique case (state)
      hnorm_pkg::ST_IDLE: begin
        // a flush before the last row is in is dropped here
        if (accept && !(op == hnorm_pkg::OP_FLUSH && !draining)) begin
          state_next = hnorm_pkg::ST_RD_CUR;
        end
      end
      hnorm_pkg::ST_RD_CUR: state_next = hnorm_pkg::ST_RD_NBR;
      hnorm_pkg::ST_RD_NBR: state_next = hnorm_pkg::ST_WRITE;
      hnorm_pkg::ST_WRITE: begin
        ram_we     = 1'b1;
        state_next = cur_emit ? hnorm_pkg::ST_MUL_A : hnorm_pkg::ST_IDLE;
      end
      hnorm_pkg::ST_MUL_A: state_next = hnorm_pkg::ST_MUL_B;
      hnorm_pkg::ST_MUL_B: state_next = hnorm_pkg::ST_MUL_C;
      hnorm_pkg::ST_MUL_C: begin
        math_start = 1'b1;
        state_next = hnorm_pkg::ST_MATH;
      end
      hnorm_pkg::ST_MATH: if (math_done) state_next = hnorm_pkg::ST_OUT;
      hnorm_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = hnorm_pkg::ST_IDLE;
        end
      end
      default: state_next = hnorm_pkg::ST_IDLE;
    endcase
  end

  // latch item context and walk the raster
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (state == hnorm_pkg::ST_WRITE) begin
      if (cur_last_col) begin
        col_cnt <= '0;
        row_cnt <= cur_drain ? '0 : row_cnt + SW'(1);
      end else begin
        col_cnt <= cur_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == hnorm_pkg::ST_IDLE) begin
      cur_col      <= col_cl;
      cur_row      <= CW'(row_cnt - SW'(1));
      cur_pixel    <= pixel_value;
      cur_drain    <= draining;
      cur_emit     <= draining || (row_cnt != '0);
      cur_down     <= row_cnt >= SW'(2);
      cur_left     <= col_cl != '0;
      cur_right    <= col_cl != side_m1;
      cur_last_col <= col_cl == side_m1;
    end
    if (state == hnorm_pkg::ST_RD_NBR) begin
      prev_c <= prev_rdata;
      mid_c  <= mid_rdata;
    end
    if (state == hnorm_pkg::ST_WRITE) begin
      prev_l <= prev_rdata;
      mid_r  <= mid_rdata;
    end
  end

  // first read the column itself, then its left and right neighbours
  always_comb begin
    if (state == hnorm_pkg::ST_RD_NBR) begin
      ram_raddr_prev = cur_col - CW'(1);
      ram_raddr_mid  = cur_col + CW'(1);
    end else begin
      ram_raddr_prev = cur_col;
      ram_raddr_mid  = cur_col;
    end
  end

  // row above the emitted one
  hnorm_ram #(.WIDTH(8), .DEPTH(MAX_SIDE)) u_prev_row (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_col),
    .wdata (mid_c),
    .raddr (ram_raddr_prev),
    .rdata (prev_rdata)
  );

  // emitted row; no new pixel is written while draining
  hnorm_ram #(.WIDTH(8), .DEPTH(MAX_SIDE)) u_mid_row (
    .clk   (clk),
    .we    (ram_we && !cur_drain),
    .waddr (cur_col),
    .wdata (cur_pixel),
    .raddr (ram_raddr_mid),
    .rdata (mid_rdata)
  );

  // neighbour levels, zero outside the image
  assign s_c = hnorm_pkg::pix_level(mid_c);
  assign s_d = cur_down  ? hnorm_pkg::pix_level(prev_c) : 10'sd0;
  assign s_l = cur_left  ? hnorm_pkg::pix_level(prev_l) : 10'sd0;
  assign s_r = cur_right ? hnorm_pkg::pix_level(mid_r)  : 10'sd0;
  assign s_u = cur_drain ? 10'sd0 : hnorm_pkg::pix_level(cur_pixel);

  always_comb begin
    priority case (state)
      hnorm_pkg::ST_MUL_A: mul_op = s_l - s_r;
      hnorm_pkg::ST_MUL_B: mul_op = s_d - s_u;
      default:             mul_op = s_c;
    endcase
  end

  assign mul_res = mul_op * $signed({1'b0, height_gain});

  always_ff @(posedge clk) begin
    unique case (state)
      hnorm_pkg::ST_MUL_A: diff_a <= 26'(mul_res);
      hnorm_pkg::ST_MUL_B: diff_b <= 26'(mul_res);
      hnorm_pkg::ST_MUL_C: hc     <= 25'(mul_res);
      default: ;
    endcase
  end

  hnorm_math u_math (
    .clk    (clk),
    .rst    (rst),
    .start  (math_start),
    .a      (diff_a),
    .b      (diff_b),
    .done   (math_done),
    .result (math_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      height_value <= height_enable ? hc : 25'sd0;
      normal_x     <= math_res.nx;
      normal_y     <= math_res.ny;
      normal_z     <= math_res.nz;
      pixel_column <= cur_col;
      pixel_row    <= cur_row;
      frame_last   <= cur_drain && cur_last_col;
    end
  end

endmodule

[rtl/hnorm_checker.sv]
// ----------------------------------------------------------------------------
// hnorm_checker
// port level checks on the heightmap normal generator
// ----------------------------------------------------------------------------
`include "heightmap_normal_generator_core_defines.svh"

module hnorm_checker #(
  parameter int MAX_SIDE = hnorm_pkg::MAX_SIDE_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        op,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [24:0]          height_value,
  input logic signed [15:0]          normal_x,
  input logic [14:0]                 normal_y,
  input logic signed [15:0]          normal_z,
  input logic [$clog2(MAX_SIDE)-1:0] pixel_column,
  input logic [$clog2(MAX_SIDE)-1:0] pixel_row,
  input logic                        frame_last
);

  // a stalled result holds
  `HNORM_ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(height_value) && $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(pixel_column) && $stable(pixel_row) && $stable(frame_last))

  // a pixel item always goes through the row memories
  `HNORM_ASSERT_CLK(a_pixel_busy, clk, rst, in_valid && !in_stall && op == hnorm_pkg::OP_PIXEL |=> in_stall)

  // reset empties the output register
  `HNORM_ASSERT_RAW(a_reset_empty, clk, $past(rst) |-> !out_valid)

endmodule

bind heightmap_normal_generator_core hnorm_checker #(.MAX_SIDE(MAX_SIDE)) u_hnorm_checker (.*);
